### src/dhfk_pkg.sv
`timescale 1ns / 1ps

package dhfk_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int NUM_JOINTS   = 6;
    localparam int JOINT_W      = 3;
    localparam int REG_W        = FRAC_BITS + 3;
    localparam int ROT_W        = FRAC_BITS + 2;
    localparam int POS_W        = FRAC_BITS + 3;
    localparam int IN_W         = ((NUM_JOINTS * ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 9 * ROT_W + 3 * POS_W;
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 3;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int ZW           = 33;
    localparam int CS_SHIFT     = 30 - FRAC_BITS;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    localparam int PROD_W  = 2 * ROT_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int LPROD_W = REG_W + ROT_W;
    localparam int LINK_W  = LPROD_W - FRAC_BITS;
    localparam int Q_W     = ROT_W + LINK_W;
    localparam int QSUM_W  = Q_W + 2;
    localparam int PACC_W  = QSUM_W - FRAC_BITS + 3;

    localparam logic signed [REG_W-1:0] RST_D1 = REG_W'(5843);
    localparam logic signed [REG_W-1:0] RST_A2 = -REG_W'(27853);
    localparam logic signed [REG_W-1:0] RST_A3 = -REG_W'(25707);
    localparam logic signed [REG_W-1:0] RST_D4 = REG_W'(7153);
    localparam logic signed [REG_W-1:0] RST_D5 = REG_W'(6203);
    localparam logic signed [REG_W-1:0] RST_D6 = REG_W'(5394);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_D1 = 3'd0,
        REG_A2 = 3'd1,
        REG_A3 = 3'd2,
        REG_D4 = 3'd3,
        REG_D5 = 3'd4,
        REG_D6 = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        TW_ZERO,
        TW_POS90,
        TW_NEG90
    } t_twist;

    typedef enum logic [1:0] {
        ST_MUL,
        ST_ROT,
        ST_POS,
        ST_OUT
    } t_chain_state;

    typedef struct packed {
        logic signed [ROT_W-1:0] cos_v;
        logic signed [ROT_W-1:0] sin_v;
    } t_cs;

    typedef struct packed {
        logic signed [REG_W-1:0] d1;
        logic signed [REG_W-1:0] a2;
        logic signed [REG_W-1:0] a3;
        logic signed [REG_W-1:0] d4;
        logic signed [REG_W-1:0] d5;
        logic signed [REG_W-1:0] d6;
    } t_link_cfg;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ZW-1:0]       z;
        logic                       flip;
    } t_cordic_stage;

    typedef struct packed {
        logic wr;
        logic full;
        logic rd;
        logic empty;
    } t_queue_status;

    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_twist f_twist(input logic [JOINT_W-1:0] j);
        t_twist t;
        case (j)
            3'd0:    t = TW_POS90;
            3'd3:    t = TW_POS90;
            3'd4:    t = TW_NEG90;
            default: t = TW_ZERO;
        endcase
        return t;
    endfunction

    function automatic logic signed [ROT_W-1:0] f_cs_round(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] t;
        logic signed [CORDIC_W-1:0] one;
        one = CORDIC_W'(1) <<< FRAC_BITS;
        t = (v + (CORDIC_W'(1) <<< (CS_SHIFT - 1))) >>> CS_SHIFT;
        if (t > one) begin
            t = one;
        end else if (t < -one) begin
            t = -one;
        end
        return t[ROT_W-1:0];
    endfunction

    function automatic logic signed [ROT_W-1:0] f_rot_round(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] one;
        one = ACC_W'(1) <<< FRAC_BITS;
        t = (v + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > one) begin
            t = one;
        end else if (t < -one) begin
            t = -one;
        end
        return t[ROT_W-1:0];
    endfunction

    function automatic logic signed [LINK_W-1:0] f_link_round(
        input logic signed [LPROD_W-1:0] v
    );
        logic signed [LPROD_W-1:0] t;
        t = (v + (LPROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return t[LINK_W-1:0];
    endfunction

endpackage

### src/dhfk_front.sv
`timescale 1ns / 1ps

module dhfk_front #(
    parameter int QUEUE_AW = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    input  logic [dhfk_pkg::IN_W-1:0]          i_s_data,
    output logic                               o_s_ready,
    input  logic                               i_pop,
    output logic                               o_issue,
    output logic [dhfk_pkg::ANGLE_BITS-1:0]    o_angle
);

    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    logic [dhfk_pkg::ANGLE_BITS-1:0] r_ang [dhfk_pkg::NUM_JOINTS];
    logic                            r_busy;
    logic [dhfk_pkg::JOINT_W-1:0]    r_idx;
    logic [QUEUE_AW:0]               r_credit;
    logic [QUEUE_AW:0]               n_credit;
    logic                            w_last;
    logic                            w_acc;

    assign o_issue   = r_busy && (r_credit < (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign w_last    = o_issue && (r_idx == dhfk_pkg::JOINT_W'(dhfk_pkg::NUM_JOINTS - 1));
    assign o_s_ready = !r_busy || w_last;
    assign w_acc     = i_s_valid && o_s_ready;
    assign o_angle   = r_ang[r_idx];

    always_comb begin
        n_credit = r_credit;
        if (o_issue && !i_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!o_issue && i_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
            if (w_acc) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_last) begin
                r_busy <= 1'b0;
            end else if (o_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int j = 0; j < dhfk_pkg::NUM_JOINTS; j++) begin
                r_ang[j] <= i_s_data[j*dhfk_pkg::ANGLE_BITS +: dhfk_pkg::ANGLE_BITS];
            end
        end
    end

endmodule

### src/dhfk_cordic.sv
`timescale 1ns / 1ps

module dhfk_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [dhfk_pkg::ANGLE_BITS-1:0] i_angle,
    output logic                            o_valid,
    output dhfk_pkg::t_cs                   o_cs
);

    localparam int STEPS = dhfk_pkg::CORDIC_STEPS;
    localparam int ZW    = dhfk_pkg::ZW;
    localparam int CW    = dhfk_pkg::CORDIC_W;
    localparam logic signed [ZW-1:0] Z_QTR  = ZW'(1) <<< 30;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< 31;

    logic                           r_valid [STEPS+1];
    dhfk_pkg::t_cordic_stage        r_st    [STEPS+1];
    dhfk_pkg::t_cordic_stage        w_fold;
    logic [31:0]                    w_turn;
    logic signed [ZW-1:0]           w_z0;
    logic signed [CW-1:0]           w_xf;
    logic signed [CW-1:0]           w_yf;

    always_comb begin
        w_turn      = {i_angle, {(32 - dhfk_pkg::ANGLE_BITS){1'b0}}};
        w_z0        = ZW'(signed'(w_turn));
        w_fold.x    = CW'(signed'({1'b0, dhfk_pkg::CORDIC_GAIN}));
        w_fold.y    = '0;
        w_fold.z    = w_z0;
        w_fold.flip = 1'b0;
        if (w_z0 > Z_QTR) begin
            w_fold.z    = w_z0 - Z_HALF;
            w_fold.flip = 1'b1;
        end else if (w_z0 < -Z_QTR) begin
            w_fold.z    = w_z0 + Z_HALF;
            w_fold.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= w_fold;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ATAN = signed'({1'b0, dhfk_pkg::f_atan(i)});
        dhfk_pkg::t_cordic_stage w_nxt;

        always_comb begin
            w_nxt.flip = r_st[i].flip;
            if (r_st[i].z >= 0) begin
                w_nxt.x = r_st[i].x - (r_st[i].y >>> i);
                w_nxt.y = r_st[i].y + (r_st[i].x >>> i);
                w_nxt.z = r_st[i].z - ATAN;
            end else begin
                w_nxt.x = r_st[i].x + (r_st[i].y >>> i);
                w_nxt.y = r_st[i].y - (r_st[i].x >>> i);
                w_nxt.z = r_st[i].z + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[i+1] <= w_nxt;
        end
    end

    always_comb begin
        w_xf = r_st[STEPS].flip ? -r_st[STEPS].x : r_st[STEPS].x;
        w_yf = r_st[STEPS].flip ? -r_st[STEPS].y : r_st[STEPS].y;
    end

    assign o_valid     = r_valid[STEPS];
    assign o_cs.cos_v  = dhfk_pkg::f_cs_round(w_xf);
    assign o_cs.sin_v  = dhfk_pkg::f_cs_round(w_yf);

endmodule

### src/dhfk_queue.sv
`timescale 1ns / 1ps

module dhfk_queue #(
    parameter int QUEUE_AW = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  dhfk_pkg::t_cs            i_wdata,
    input  logic                     i_rd,
    output dhfk_pkg::t_cs            o_rdata,
    output dhfk_pkg::t_queue_status  o_status
);

    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    dhfk_pkg::t_cs       r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   r_wr_ptr;
    logic [QUEUE_AW:0]   r_rd_ptr;
    logic                w_empty;
    logic                w_full;

    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign w_full  = (r_wr_ptr[QUEUE_AW] != r_rd_ptr[QUEUE_AW])
                  && (r_wr_ptr[QUEUE_AW-1:0] == r_rd_ptr[QUEUE_AW-1:0]);
    assign o_rdata = r_mem[r_rd_ptr[QUEUE_AW-1:0]];

    assign o_status.wr    = i_wr;
    assign o_status.full  = w_full;
    assign o_status.rd    = i_rd;
    assign o_status.empty = w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr[QUEUE_AW-1:0]] <= i_wdata;
        end
    end

endmodule

### src/dhfk_chain.sv
`timescale 1ns / 1ps

module dhfk_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dhfk_pkg::t_link_cfg           i_cfg,
    input  dhfk_pkg::t_cs                 i_cs,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [dhfk_pkg::OUT_W-1:0]    o_m_data
);

    localparam int F      = dhfk_pkg::FRAC_BITS;
    localparam int ROT_W  = dhfk_pkg::ROT_W;
    localparam int PROD_W = dhfk_pkg::PROD_W;
    localparam int ACC_W  = dhfk_pkg::ACC_W;
    localparam int LINK_W = dhfk_pkg::LINK_W;
    localparam int Q_W    = dhfk_pkg::Q_W;
    localparam int QSUM_W = dhfk_pkg::QSUM_W;
    localparam int PACC_W = dhfk_pkg::PACC_W;
    localparam int POS_W  = dhfk_pkg::POS_W;
    localparam logic signed [ROT_W-1:0]  ONE_ROT = ROT_W'(1) <<< F;
    localparam logic signed [PACC_W-1:0] POS_HI  = (PACC_W'(1) <<< (POS_W - 1)) - 1;
    localparam logic signed [PACC_W-1:0] POS_LO  = -(PACC_W'(1) <<< (POS_W - 1));

    dhfk_pkg::t_chain_state r_state;
    dhfk_pkg::t_chain_state n_state;
    logic [dhfk_pkg::JOINT_W-1:0] r_j;

    logic signed [ROT_W-1:0]  r_rot [3][3];
    logic signed [ROT_W-1:0]  n_rot [3][3];
    logic signed [PACC_W-1:0] r_pos [3];
    logic signed [PROD_W-1:0] r_p0c [3];
    logic signed [PROD_W-1:0] r_p1s [3];
    logic signed [PROD_W-1:0] r_p0s [3];
    logic signed [PROD_W-1:0] r_p1c [3];
    logic signed [dhfk_pkg::LPROD_W-1:0] r_lk_c;
    logic signed [dhfk_pkg::LPROD_W-1:0] r_lk_s;
    logic signed [Q_W-1:0]    r_q [3][3];
    logic signed [Q_W-1:0]    n_q [3][3];
    logic                     r_pp_valid;
    logic                     r_out_valid;
    logic [dhfk_pkg::OUT_W-1:0] r_out_data;
    logic [dhfk_pkg::OUT_W-1:0] w_out_data;

    logic signed [dhfk_pkg::REG_W-1:0] w_a;
    logic signed [dhfk_pkg::REG_W-1:0] w_d;
    logic signed [LINK_W-1:0]          w_lk [3];
    logic                              w_out_free;
    logic                              w_load_out;
    logic                              w_mul;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign o_m_valid  = r_out_valid;
    assign o_m_data   = r_out_data;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dhfk_pkg::ST_MUL: begin
                if (!i_empty) begin
                    n_state = dhfk_pkg::ST_ROT;
                end
            end
            dhfk_pkg::ST_ROT: begin
                if (r_j == dhfk_pkg::JOINT_W'(dhfk_pkg::NUM_JOINTS - 1)) begin
                    n_state = dhfk_pkg::ST_POS;
                end else begin
                    n_state = dhfk_pkg::ST_MUL;
                end
            end
            dhfk_pkg::ST_POS: n_state = dhfk_pkg::ST_OUT;
            dhfk_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = dhfk_pkg::ST_MUL;
                end
            end
            default: n_state = dhfk_pkg::ST_MUL;
        endcase
    end

    always_comb begin
        w_mul      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            dhfk_pkg::ST_MUL: w_mul = !i_empty;
            dhfk_pkg::ST_OUT: w_load_out = w_out_free;
            default: begin
                w_mul      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign o_pop = w_mul;

    always_comb begin
        case (r_j)
            3'd1:    w_a = i_cfg.a2;
            3'd2:    w_a = i_cfg.a3;
            default: w_a = '0;
        endcase
        case (r_j)
            3'd0:    w_d = i_cfg.d1;
            3'd3:    w_d = i_cfg.d4;
            3'd4:    w_d = i_cfg.d5;
            3'd5:    w_d = i_cfg.d6;
            default: w_d = '0;
        endcase
    end

    always_comb begin
        logic signed [ACC_W-1:0] acc0;
        logic signed [ACC_W-1:0] acc1;
        logic signed [ACC_W-1:0] acc2;
        logic signed [ACC_W-1:0] r2s;
        w_lk[0] = dhfk_pkg::f_link_round(r_lk_c);
        w_lk[1] = dhfk_pkg::f_link_round(r_lk_s);
        w_lk[2] = LINK_W'(w_d);
        for (int r = 0; r < 3; r++) begin
            acc0 = ACC_W'(r_p0c[r]) + ACC_W'(r_p1s[r]);
            r2s  = ACC_W'(r_rot[r][2]) <<< F;
            case (dhfk_pkg::f_twist(r_j))
                dhfk_pkg::TW_POS90: begin
                    acc1 = r2s;
                    acc2 = ACC_W'(r_p0s[r]) - ACC_W'(r_p1c[r]);
                end
                dhfk_pkg::TW_NEG90: begin
                    acc1 = -r2s;
                    acc2 = ACC_W'(r_p1c[r]) - ACC_W'(r_p0s[r]);
                end
                default: begin
                    acc1 = ACC_W'(r_p1c[r]) - ACC_W'(r_p0s[r]);
                    acc2 = r2s;
                end
            endcase
            n_rot[r][0] = dhfk_pkg::f_rot_round(acc0);
            n_rot[r][1] = dhfk_pkg::f_rot_round(acc1);
            n_rot[r][2] = dhfk_pkg::f_rot_round(acc2);
            for (int k = 0; k < 3; k++) begin
                n_q[r][k] = Q_W'(r_rot[r][k]) * Q_W'(w_lk[k]);
            end
        end
    end

    always_comb begin
        logic signed [PACC_W-1:0] sat [3];
        for (int r = 0; r < 3; r++) begin
            if (r_pos[r] > POS_HI) begin
                sat[r] = POS_HI;
            end else if (r_pos[r] < POS_LO) begin
                sat[r] = POS_LO;
            end else begin
                sat[r] = r_pos[r];
            end
        end
        w_out_data = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_out_data[(r*3+k)*ROT_W +: ROT_W] = r_rot[r][k];
            end
            w_out_data[9*ROT_W + r*POS_W +: POS_W] = sat[r][POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [QSUM_W-1:0] qs;
        logic signed [QSUM_W-1:0] qr;
        if (!i_rst_n) begin
            r_state     <= dhfk_pkg::ST_MUL;
            r_j         <= '0;
            r_pp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_pos[r] <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_rot[r][k] <= (r == k) ? ONE_ROT : '0;
                end
            end
        end else begin
            r_state    <= n_state;
            r_pp_valid <= (r_state == dhfk_pkg::ST_ROT);
            if (r_state == dhfk_pkg::ST_ROT) begin
                r_rot <= n_rot;
                if (r_j != dhfk_pkg::JOINT_W'(dhfk_pkg::NUM_JOINTS - 1)) begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_pp_valid) begin
                for (int r = 0; r < 3; r++) begin
                    qs = QSUM_W'(r_q[r][0]) + QSUM_W'(r_q[r][1]) + QSUM_W'(r_q[r][2]);
                    qr = (qs + (QSUM_W'(1) <<< (F - 1))) >>> F;
                    r_pos[r] <= r_pos[r] + PACC_W'(qr);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_j         <= '0;
                for (int r = 0; r < 3; r++) begin
                    r_pos[r] <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_rot[r][k] <= (r == k) ? ONE_ROT : '0;
                    end
                end
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            for (int r = 0; r < 3; r++) begin
                r_p0c[r] <= PROD_W'(r_rot[r][0]) * PROD_W'(i_cs.cos_v);
                r_p1s[r] <= PROD_W'(r_rot[r][1]) * PROD_W'(i_cs.sin_v);
                r_p0s[r] <= PROD_W'(r_rot[r][0]) * PROD_W'(i_cs.sin_v);
                r_p1c[r] <= PROD_W'(r_rot[r][1]) * PROD_W'(i_cs.cos_v);
            end
            r_lk_c <= dhfk_pkg::LPROD_W'(w_a) * dhfk_pkg::LPROD_W'(i_cs.cos_v);
            r_lk_s <= dhfk_pkg::LPROD_W'(w_a) * dhfk_pkg::LPROD_W'(i_cs.sin_v);
        end
        if (r_state == dhfk_pkg::ST_ROT) begin
            r_q <= n_q;
        end
        if (w_load_out) begin
            r_out_data <= w_out_data;
        end
    end

endmodule

### src/dh_forward_kinematics_6dof.sv
`timescale 1ns / 1ps
// Each input transaction is issued joint by joint through the sine and cosine pipeline and a queue
// to the chaining unit, which limits throughput: it handles one transaction at a time and steps
// through each joint with a multiply step, then a round and position products step.
// The sine and cosine pipeline takes one joint angle per cycle.
// Reset is synchronous and active low; it clears control state and loads the
// default link lengths and offsets.

module dh_forward_kinematics_6dof #(
    parameter int QUEUE_AW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // angle_joint1 .. angle_joint6, 16 bits each
    input  logic [dhfk_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rot_r0c0 .. rot_r2c2 (18 bits each), pos_x, pos_y, pos_z (19 bits each), zero fill
    output logic [dhfk_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [dhfk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dhfk_pkg::REG_W-1:0]        i_cfg_wdata
);

    dhfk_pkg::t_link_cfg              r_cfg;
    logic                             w_issue;
    logic [dhfk_pkg::ANGLE_BITS-1:0]  w_angle;
    logic                             w_cs_valid;
    dhfk_pkg::t_cs                    w_cs;
    dhfk_pkg::t_cs                    w_q_data;
    dhfk_pkg::t_queue_status          w_q_status;
    logic                             w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.d1 <= dhfk_pkg::RST_D1;
            r_cfg.a2 <= dhfk_pkg::RST_A2;
            r_cfg.a3 <= dhfk_pkg::RST_A3;
            r_cfg.d4 <= dhfk_pkg::RST_D4;
            r_cfg.d5 <= dhfk_pkg::RST_D5;
            r_cfg.d6 <= dhfk_pkg::RST_D6;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dhfk_pkg::REG_D1: r_cfg.d1 <= i_cfg_wdata;
                dhfk_pkg::REG_A2: r_cfg.a2 <= i_cfg_wdata;
                dhfk_pkg::REG_A3: r_cfg.a3 <= i_cfg_wdata;
                dhfk_pkg::REG_D4: r_cfg.d4 <= i_cfg_wdata;
                dhfk_pkg::REG_D5: r_cfg.d5 <= i_cfg_wdata;
                dhfk_pkg::REG_D6: r_cfg.d6 <= i_cfg_wdata;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    dhfk_front #(
        .QUEUE_AW (QUEUE_AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_data  (s_axis_tdata),
        .o_s_ready (s_axis_tready),
        .i_pop     (w_pop),
        .o_issue   (w_issue),
        .o_angle   (w_angle)
    );

    dhfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_angle (w_angle),
        .o_valid (w_cs_valid),
        .o_cs    (w_cs)
    );

    dhfk_queue #(
        .QUEUE_AW (QUEUE_AW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_cs_valid),
        .i_wdata  (w_cs),
        .i_rd     (w_pop),
        .o_rdata  (w_q_data),
        .o_status (w_q_status)
    );

    dhfk_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cs      (w_q_data),
        .i_empty   (w_q_status.empty),
        .o_pop     (w_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.wr && w_q_status.full && !w_q_status.rd))
        else $error("sine/cosine queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.rd && w_q_status.empty))
        else $error("sine/cosine queue read while empty");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");
`endif

endmodule
